// ===== src/delayed_pd_joint_torque_defines.svh =====
// Assertion macros used by the port checker file.
`ifndef DELAYED_PD_JOINT_TORQUE_DEFINES_SVH
`define DELAYED_PD_JOINT_TORQUE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DPJT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DPJT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== src/dpjt_pkg.sv =====
// Package with shared types and constants of the delayed PD joint torque block.
package dpjt_pkg;
    localparam int unsigned StampW = 63;
    localparam int unsigned DataW  = 32;
    localparam int unsigned DelayW = 30;

    // One queued command entry.
    typedef struct packed {
        logic [StampW-1:0] stamp;
        logic [DataW-1:0]  pos;
        logic [DataW-1:0]  vel;
        logic [DataW-1:0]  kp;
        logic [DataW-1:0]  kd;
        logic [DataW-1:0]  ff;
    } t_entry;

    // Classified job passed from the front to the back.
    typedef struct packed {
        logic [3:0]        joint;
        logic              in_range;
        logic [StampW-1:0] stamp;
        logic [DataW-1:0]  pos;
        logic [DataW-1:0]  vel;
        logic [DataW-1:0]  kp;
        logic [DataW-1:0]  kd;
        logic [DataW-1:0]  ff;
        logic [DataW-1:0]  mpos;
        logic [DataW-1:0]  mvel;
    } t_job;
endpackage

// ===== src/dpjt_if.sv =====
// Valid/ready channel interfaces for the delayed PD joint torque block.
interface dpjt_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  joint_index;
    logic [62:0] time_ns;
    logic [31:0] position_target;
    logic [31:0] velocity_target;
    logic [31:0] stiffness_gain;
    logic [31:0] damping_gain;
    logic [31:0] feedforward_torque;
    logic [31:0] measured_position;
    logic [31:0] measured_velocity;
    modport source (output valid, joint_index, time_ns, position_target, velocity_target,
        stiffness_gain, damping_gain, feedforward_torque, measured_position,
        measured_velocity, input ready);
    modport sink (input valid, joint_index, time_ns, position_target, velocity_target,
        stiffness_gain, damping_gain, feedforward_torque, measured_position,
        measured_velocity, output ready);
endinterface

interface dpjt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  joint_out;
    logic [31:0] torque_command;
    logic        torque_saturated;
    logic        queue_overflow;
    modport source (output valid, joint_out, torque_command, torque_saturated,
        queue_overflow, input ready);
    modport sink (input valid, joint_out, torque_command, torque_saturated,
        queue_overflow, output ready);
endinterface

interface dpjt_cfg_if;
    logic        valid;
    logic        ready;
    logic [29:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// ===== src/dpjt_front.sv =====
// Front end: accepts input beats, classifies the joint and fills a two-entry job queue.
module dpjt_front #(
    parameter int unsigned JOINT_COUNT = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dpjt_in_if.sink         in_ch,
    output logic            o_job_valid,
    output dpjt_pkg::t_job  o_job,
    input  logic            i_job_take
);
    dpjt_pkg::t_job r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           acc;
    dpjt_pkg::t_job job_in;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign acc         = in_ch.valid && in_ch.ready;

    // Classify the incoming beat.
    always_comb begin
        job_in.joint    = in_ch.joint_index;
        job_in.in_range = ({28'd0, in_ch.joint_index} < JOINT_COUNT);
        job_in.stamp    = in_ch.time_ns;
        job_in.pos      = in_ch.position_target;
        job_in.vel      = in_ch.velocity_target;
        job_in.kp       = in_ch.stiffness_gain;
        job_in.kd       = in_ch.damping_gain;
        job_in.ff       = in_ch.feedforward_torque;
        job_in.mpos     = in_ch.measured_position;
        job_in.mvel     = in_ch.measured_velocity;
    end

    // Job queue storage and pointers.
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wp] <= job_in;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (acc) begin
                r_wp <= ~r_wp;
            end
            if (i_job_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, i_job_take};
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];
endmodule

// ===== src/dpjt_back.sv =====
// Back end: per-joint command queues, pruning sequencer and torque arithmetic.
module dpjt_back #(
    parameter int unsigned JOINT_COUNT = 16,
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [29:0]           i_delay,
    input  logic                  i_job_valid,
    input  dpjt_pkg::t_job        i_job,
    output logic                  o_job_take,
    dpjt_out_if.source            out_ch
);
    localparam int unsigned JW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam int unsigned QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SLOTS = JOINT_COUNT * QUEUE_DEPTH;
    localparam int unsigned AW    = $clog2(SLOTS);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_PUSH = 7'b0001000,
        S_HEAD = 7'b0010000,
        S_MUL  = 7'b0100000,
        S_SUM  = 7'b1000000
    } t_state;

    t_state                r_st;
    dpjt_pkg::t_entry      r_mem [SLOTS];
    dpjt_pkg::t_entry      r_rd;
    logic [QW-1:0]         r_head [JOINT_COUNT];
    logic [CW-1:0]         r_cnt  [JOINT_COUNT];
    dpjt_pkg::t_job        r_job;
    logic [JW-1:0]         r_j;
    logic                  r_ovf;
    logic                  r_nk, r_nd;
    logic [63:0]           r_ph, r_pl, r_dh, r_dl;
    logic                  r_ov_valid;
    logic [3:0]            r_oj;
    logic [31:0]           r_ot;
    logic                  r_os, r_oo;

    logic                  wr_en;
    logic [AW-1:0]         wr_addr, rd_addr;
    logic [QW-1:0]         head, tail, head_inc;
    logic [CW:0]           tail_sum;
    logic [CW-1:0]         cnt;
    logic [63:0]           lim;
    logic                  stale;
    logic [33:0]           dp, dv;
    logic [32:0]           mp, mv;
    logic [65:0]           sum;
    logic [65:0]           tk, td;
    logic                  out_free;
    logic                  out_load;

    assign head     = r_head[r_j];
    assign cnt      = r_cnt[r_j];
    assign wr_addr  = AW'(r_j * QUEUE_DEPTH + tail);
    assign out_free = !r_ov_valid || out_ch.ready;
    assign out_load = (r_st == S_SUM) && out_free;
    assign o_job_take = (r_st == S_IDLE) && i_job_valid;

    // Ring arithmetic: the tail slot and the slot after the head.
    always_comb begin
        tail_sum = (CW+1)'(head) + (CW+1)'(cnt);
        if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
        end
        tail     = tail_sum[QW-1:0];
        head_inc = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + QW'(1);
    end

    always_comb begin
        rd_addr = AW'(r_j * QUEUE_DEPTH + head);
        if (r_st == S_IDLE) begin
            rd_addr = AW'(i_job.joint[JW-1:0] * QUEUE_DEPTH + r_head[i_job.joint[JW-1:0]]);
        end
    end

    // Oldest stamp plus delay, compared without wrap.
    assign lim   = {1'b0, r_rd.stamp} + {34'd0, i_delay};
    assign stale = (cnt > CW'(1)) && (lim < {1'b0, r_job.stamp});
    assign wr_en = (r_st == S_PUSH) || ((r_st == S_RD) && (cnt == '0));

    // Differences and their magnitudes.
    assign dp = {{2{r_rd.pos[31]}}, r_rd.pos} - {{2{r_job.mpos[31]}}, r_job.mpos};
    assign dv = {{2{r_rd.vel[31]}}, r_rd.vel} - {{2{r_job.mvel[31]}}, r_job.mvel};
    assign mp = dp[33] ? 33'(-dp) : dp[32:0];
    assign mv = dv[33] ? 33'(-dv) : dv[32:0];

    // Entry memory.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= '{r_job.stamp, r_job.pos, r_job.vel, r_job.kp, r_job.kd,
                r_job.ff};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign tk  = {2'b0, r_ph + (r_pl >> 16)};
    assign td  = {2'b0, r_dh + (r_dl >> 16)};
    assign sum = (r_nk ? 66'(-tk) : tk) + (r_nd ? 66'(-td) : td)
        + {{34{r_rd.ff[31]}}, r_rd.ff};

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
            r_j   <= i_job.joint[JW-1:0];
        end
        if (r_st == S_MUL) begin
            r_nk <= dp[33];
            r_nd <= dv[33];
            r_ph <= {31'd0, mp} * {48'd0, r_rd.kp[31:16]};
            r_pl <= {31'd0, mp} * {48'd0, r_rd.kp[15:0]};
            r_dh <= {31'd0, mv} * {48'd0, r_rd.kd[31:16]};
            r_dl <= {31'd0, mv} * {48'd0, r_rd.kd[15:0]};
        end
        if (!i_rst_n) begin
            r_st       <= S_IDLE;
            r_ov_valid <= 1'b0;
            r_ovf      <= 1'b0;
            for (int k = 0; k < JOINT_COUNT; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
            end
        end else begin
            if (out_load) begin
                r_ov_valid <= 1'b1;
            end else if (r_ov_valid && out_ch.ready) begin
                r_ov_valid <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_ovf <= 1'b0;
                        r_st  <= i_job.in_range ? S_RD : S_SUM;
                    end
                end
                S_RD: begin
                    // Seed an empty queue, then push the command behind it.
                    if (cnt == '0) begin
                        r_cnt[r_j] <= CW'(1);
                        r_st       <= S_PUSH;
                    end else begin
                        r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    // A stale pop goes back to read the new head and check again.
                    if (stale) begin
                        r_head[r_j] <= head_inc;
                        r_cnt[r_j]  <= cnt - CW'(1);
                        r_st        <= S_RD;
                    end else begin
                        r_st <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (cnt >= CW'(QUEUE_DEPTH)) begin
                        r_head[r_j] <= head_inc;
                        r_ovf       <= 1'b1;
                    end else begin
                        r_cnt[r_j] <= cnt + CW'(1);
                    end
                    r_st <= S_HEAD;
                end
                S_HEAD: begin
                    // Memory read of the current head completes here.
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_st <= S_SUM;
                end
                S_SUM: begin
                    if (out_load) begin
                        r_oj       <= r_job.joint;
                        r_oo       <= r_ovf;
                        if (!r_job.in_range) begin
                            r_ot <= '0;
                            r_os <= 1'b0;
                        end else if (!sum[65] && (sum[64:31] != '0)) begin
                            r_ot <= 32'h7FFF_FFFF;
                            r_os <= 1'b1;
                        end else if (sum[65] && (sum[64:31] != '1)) begin
                            r_ot <= 32'h8000_0000;
                            r_os <= 1'b1;
                        end else begin
                            r_ot <= sum[31:0];
                            r_os <= 1'b0;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid            = r_ov_valid;
    assign out_ch.joint_out        = r_oj;
    assign out_ch.torque_command   = r_ot;
    assign out_ch.torque_saturated = r_os;
    assign out_ch.queue_overflow   = r_oo;
endmodule

// ===== src/delayed_pd_joint_torque.sv =====
// Top level of the delayed PD joint torque block.
//  channel   | dir | beat
//  in_ch     | in  | one joint command with measurements
//  cfg_ch    | in  | command_delay_ns write
//  out_ch    | out | one torque result per input beat
// A result is worked out by the back-end sequencer through the registered entry
// memory read; an out-of-range joint goes straight to the sum state, and each
// stale entry pruned adds another read and check of the queue head.
// Reset is synchronous and active low; it empties all joint queues at once.
// The two-entry job queue lets input beats be taken while the back end works
// or the output register waits for ready.
module delayed_pd_joint_torque #(
    parameter int unsigned JOINT_COUNT = 16,
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpjt_in_if.sink    in_ch,
    dpjt_cfg_if.sink   cfg_ch,
    dpjt_out_if.source out_ch
);
    logic           job_valid, job_take;
    dpjt_pkg::t_job job;
    logic [29:0]    r_delay;

    // Delay register.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= '0;
        end else if (cfg_ch.valid) begin
            r_delay <= cfg_ch.data;
        end
    end

    dpjt_front #(.JOINT_COUNT(JOINT_COUNT)) u_front (
        .i_clk, .i_rst_n, .in_ch,
        .o_job_valid(job_valid), .o_job(job), .i_job_take(job_take)
    );

    dpjt_back #(.JOINT_COUNT(JOINT_COUNT), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_delay(r_delay), .i_job_valid(job_valid), .i_job(job),
        .o_job_take(job_take), .out_ch
    );
endmodule

// ===== src/dpjt_checker.sv =====
// Port checker for the delayed PD joint torque block and its bind.
`include "delayed_pd_joint_torque_defines.svh"
module dpjt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_torque,
    input logic        out_sat,
    input logic        cfg_ready
);
    `DPJT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_torque))
    `DPJT_ASSERT_IMPL(a_sat_rail, i_clk, i_rst_n, out_valid && out_sat, out_torque == 32'h7FFF_FFFF || out_torque == 32'h8000_0000)
    `DPJT_ASSERT_IMPL(a_cfg_ready, i_clk, i_rst_n, 1'b1, cfg_ready)
endmodule

bind delayed_pd_joint_torque dpjt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_torque(out_ch.torque_command), .out_sat(out_ch.torque_saturated),
    .cfg_ready(cfg_ch.ready)
);

// ===== test/delayed_pd_joint_torque_checker.sv =====
// Checker that predicts and compares the torque results of the delayed PD joint torque block.
`timescale 1ns / 100ps

module delayed_pd_joint_torque_checker #(
    parameter int unsigned JOINT_COUNT = 16,
    parameter int unsigned QUEUE_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dpjt_in_if   in_ch,
    dpjt_cfg_if  cfg_ch,
    dpjt_out_if  out_ch,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_saturations,
    output int   o_overflows
);
    localparam int unsigned SlotTotal = JOINT_COUNT * QUEUE_DEPTH;

    typedef struct {
        logic [3:0]  joint;
        logic [31:0] torque;
        logic        sat;
        logic        ovf;
    } t_torque_result;

    // Shadow copy of the per-joint command queues and the delay register.
    logic [62:0]  cmd_stamp [SlotTotal];
    logic [31:0]  cmd_pos   [SlotTotal];
    logic [31:0]  cmd_vel   [SlotTotal];
    logic [31:0]  cmd_kp    [SlotTotal];
    logic [31:0]  cmd_kd    [SlotTotal];
    logic [31:0]  cmd_ff    [SlotTotal];
    int unsigned  q_head    [JOINT_COUNT];
    int unsigned  q_fill    [JOINT_COUNT];
    logic [29:0]  delay_ns;
    t_torque_result torque_queue[$];

    assign o_pending = torque_queue.size();

    // Prints one mismatch line and counts it.
    task automatic report(input string what);
        o_fail_count++;
        $display("[%0t] torque check error: %s", $realtime, what);
    endtask

    // Gain times difference, shifted by 16 with the magnitude truncated.
    function automatic longint scaled_term(input logic [31:0] gain, input longint diff);
        logic           neg;
        logic [63:0]    mag;
        logic [63:0]    r;
        neg = diff < 0;
        mag = neg ? 64'(-diff) : 64'(diff);
        r = {48'd0, gain[31:16]} * mag + (({48'd0, gain[15:0]} * mag) >> 16);
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic void push_command(input int unsigned j, input logic [62:0] t);
        int unsigned slot;
        slot = j * QUEUE_DEPTH + (q_head[j] + q_fill[j]) % QUEUE_DEPTH;
        cmd_stamp[slot] = t;
        cmd_pos[slot]   = in_ch.position_target;
        cmd_vel[slot]   = in_ch.velocity_target;
        cmd_kp[slot]    = in_ch.stiffness_gain;
        cmd_kd[slot]    = in_ch.damping_gain;
        cmd_ff[slot]    = in_ch.feedforward_torque;
        q_fill[j]++;
    endfunction

    function automatic void drop_oldest(input int unsigned j);
        q_head[j] = (q_head[j] + 1) % QUEUE_DEPTH;
        q_fill[j]--;
    endfunction

    // Works out the torque result of the beat now on the input channel.
    function automatic t_torque_result predict_torque();
        t_torque_result res;
        int unsigned    j;
        int unsigned    slot;
        logic [62:0]    t;
        longint         sum;
        res.joint  = in_ch.joint_index;
        res.torque = '0;
        res.sat    = 1'b0;
        res.ovf    = 1'b0;
        j = in_ch.joint_index;
        t = in_ch.time_ns;
        if (j >= JOINT_COUNT) return res;
        if (q_fill[j] == 0) push_command(j, t);
        // Stale commands go while more than one is left.
        while (q_fill[j] > 1 &&
               {1'b0, cmd_stamp[j * QUEUE_DEPTH + q_head[j]]} + 64'(delay_ns) < {1'b0, t})
            drop_oldest(j);
        if (q_fill[j] >= QUEUE_DEPTH) begin
            drop_oldest(j);
            res.ovf = 1'b1;
        end
        push_command(j, t);
        slot = j * QUEUE_DEPTH + q_head[j];
        sum = scaled_term(cmd_kp[slot], longint'($signed(cmd_pos[slot]))
                  - longint'($signed(in_ch.measured_position)))
            + scaled_term(cmd_kd[slot], longint'($signed(cmd_vel[slot]))
                  - longint'($signed(in_ch.measured_velocity)))
            + longint'($signed(cmd_ff[slot]));
        if (sum > 64'sd2147483647) begin
            sum = 64'sd2147483647;
            res.sat = 1'b1;
        end else if (sum < -64'sd2147483648) begin
            sum = -64'sd2147483648;
            res.sat = 1'b1;
        end
        res.torque = sum[31:0];
        return res;
    endfunction

    initial begin
        o_fail_count  = 0;
        o_results     = 0;
        o_saturations = 0;
        o_overflows   = 0;
    end

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_torque_result want;
        if (!i_rst_n) begin
            delay_ns = '0;
            foreach (q_head[j]) begin
                q_head[j] = 0;
                q_fill[j] = 0;
            end
            torque_queue.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) delay_ns = cfg_ch.data;
            if (in_ch.valid && in_ch.ready) begin
                want = predict_torque();
                if (want.sat) o_saturations++;
                if (want.ovf) o_overflows++;
                torque_queue.insert(torque_queue.size(), want);
            end
            if (out_ch.valid && out_ch.ready) begin
                o_results++;
                if (torque_queue.size() == 0) begin
                    report("torque beat with nothing expected");
                end else begin
                    want = torque_queue.pop_front();
                    if (out_ch.joint_out !== want.joint)
                        report($sformatf("joint_out %0d, expected %0d",
                            out_ch.joint_out, want.joint));
                    if (out_ch.torque_command !== want.torque)
                        report($sformatf("joint %0d torque %h, expected %h",
                            want.joint, out_ch.torque_command, want.torque));
                    if (out_ch.torque_saturated !== want.sat)
                        report($sformatf("joint %0d saturation flag %b, expected %b",
                            want.joint, out_ch.torque_saturated, want.sat));
                    if (out_ch.queue_overflow !== want.ovf)
                        report($sformatf("joint %0d overflow flag %b, expected %b",
                            want.joint, out_ch.queue_overflow, want.ovf));
                end
            end
        end
    end
endmodule

// ===== test/delayed_pd_joint_torque_tb.sv =====
// Testbench top that drives commands, delay writes and output stalls, and gives the verdict.
`timescale 1ns / 100ps

module delayed_pd_joint_torque_tb;
    localparam logic [62:0] StampMax = {63{1'b1}};
    localparam logic [29:0] DelayMax = 30'd1000000000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   result_count;
    int   sat_count;
    int   ovf_count;
    int   sent_count;
    logic [62:0] now_ns;

    dpjt_in_if  in_ch ();
    dpjt_cfg_if cfg_ch ();
    dpjt_out_if out_ch ();

    delayed_pd_joint_torque DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .cfg_ch  (cfg_ch),
        .out_ch  (out_ch)
    );

    delayed_pd_joint_torque_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (in_ch),
        .cfg_ch        (cfg_ch),
        .out_ch        (out_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (result_count),
        .o_saturations (sat_count),
        .o_overflows   (ovf_count)
    );

    // Clock with a 2 ns period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Run limit well above the slowest correct run.
    initial begin
        #1800000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: one long hold-off early on, then a changing stall pattern.
    initial begin
        int mode;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(10, 80)) begin
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= ~out_ch.ready;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Offers one command beat and holds it until it is taken.
    task automatic offer_command(input logic [3:0] j, input logic [62:0] t,
        input logic [31:0] pos, input logic [31:0] vel, input logic [31:0] kp,
        input logic [31:0] kd, input logic [31:0] ff, input logic [31:0] mpos,
        input logic [31:0] mvel);
        in_ch.valid              <= 1'b1;
        in_ch.joint_index        <= j;
        in_ch.time_ns            <= t;
        in_ch.position_target    <= pos;
        in_ch.velocity_target    <= vel;
        in_ch.stiffness_gain     <= kp;
        in_ch.damping_gain       <= kd;
        in_ch.feedforward_torque <= ff;
        in_ch.measured_position  <= mpos;
        in_ch.measured_velocity  <= mvel;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic go_idle(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Writes the delay register once every torque result is back.
    task automatic set_delay(input logic [29:0] value);
        go_idle(1);
        while (pending != 0) @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly modest values so the torque stays in range, sometimes full scale.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return $urandom_range(0, 32'h3ffff);
            default: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom())};
        endcase
    endfunction

    // Time normally runs forward; now and then it jumps back or far ahead.
    function automatic logic [62:0] next_stamp();
        case ($urandom_range(0, 49))
            0: now_ns = now_ns - 63'($urandom_range(0, 5000));
            1: return 63'({$urandom(), $urandom()});
            default: now_ns = now_ns + 63'($urandom_range(0, 3000));
        endcase
        return now_ns;
    endfunction

    // A burst of random commands over a few joints or all of them.
    task automatic random_phase(input int items);
        int left;
        int burst;
        logic [3:0] jmask;
        left = items;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            jmask = ($urandom_range(0, 1) == 1) ? 4'hf : 4'h3;
            while (burst > 0 && left > 0) begin
                offer_command(4'($urandom()) & jmask, next_stamp(), pick_value(),
                    pick_value(), pick_value(), pick_value(), pick_value(),
                    pick_value(), pick_value());
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) go_idle($urandom_range(1, 12));
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        sent_count   = 0;
        now_ns       = 63'd100;
        in_ch.valid  = 1'b0;
        in_ch.joint_index = '0;
        in_ch.time_ns = '0;
        in_ch.position_target = '0;
        in_ch.velocity_target = '0;
        in_ch.stiffness_gain = '0;
        in_ch.damping_gain = '0;
        in_ch.feedforward_torque = '0;
        in_ch.measured_position = '0;
        in_ch.measured_velocity = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: seeding, field extremes, saturation both ways, far timestamps.
        offer_command(4'd0, 63'd0, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0,
            32'h0, 32'h0, 32'h0);
        offer_command(4'd15, StampMax, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff,
            32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        offer_command(4'd14, 63'd5, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff,
            32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        offer_command(4'd13, 63'd7, 32'hffff_ffff, 32'h0000_0001, 32'h0000_ffff,
            32'h0001_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff);
        offer_command(4'd0, 63'd10, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h1234_5678, 32'h8765_4321);
        offer_command(4'd15, StampMax - 63'd1, 32'h0, 32'h0, 32'h0, 32'h0,
            32'h0, 32'h0, 32'h0);
        offer_command(4'd15, 63'd0, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
            32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555);
        // Zero delay: each later stamp retires the previous command.
        repeat (5) offer_command(4'd1, next_stamp(), pick_value(), pick_value(),
            pick_value(), pick_value(), pick_value(), pick_value(), pick_value());

        // A one-second delay: one joint overflows its queue.
        set_delay(DelayMax);
        repeat (36) offer_command(4'd2, next_stamp(), pick_value(), pick_value(),
            pick_value(), pick_value(), pick_value(), pick_value(), pick_value());

        // Random phases under several delay settings, extremes included.
        set_delay(30'd0);
        random_phase(350);
        set_delay(30'd1500);
        random_phase(350);
        set_delay(DelayMax);
        random_phase(350);
        set_delay(30'($urandom_range(0, 40000)));
        random_phase(250);
        set_delay({30{1'b1}});
        random_phase(200);

        go_idle(1);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d joint commands, checked %0d torque results.",
            sent_count, result_count);
        $display("Saturated torques: %0d, queue overflows: %0d.", sat_count, ovf_count);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/dpjt_pkg.sv
src/dpjt_if.sv
src/dpjt_front.sv
src/dpjt_back.sv
src/delayed_pd_joint_torque.sv
src/dpjt_checker.sv
test/delayed_pd_joint_torque_checker.sv
test/delayed_pd_joint_torque_tb.sv
